### rtl/gtj_pkg.sv
// Shared types, constants and tables for the Gregorian to Jalali date unit.
package gtj_pkg;

  // Field and stream widths
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int TDATA_W = 24;

  // Shared divider widths: dividend, quotient, remainder/divisor, product
  localparam int DIV_W  = 22;
  localparam int QUO_W  = 8;
  localparam int REM_W  = 14;
  localparam int PROD_W = 2 * DIV_W;

  // Day count after the year step fits in 11 bits (below 1461)
  localparam int DAYS_W = 11;

  // Input saturation limits
  localparam logic [YEAR_W-1:0]  GY_MIN    = 14'd1601;
  localparam logic [YEAR_W-1:0]  GY_MAX    = 14'd9999;
  localparam logic [YEAR_W-1:0]  BASE_YEAR = 14'd1600;
  localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;

  // Calendar constants
  localparam logic [8:0]        DAYS_YEAR      = 9'd365;
  localparam logic [DAYS_W-1:0] DAYS_LEAP_YEAR = 11'd366;
  localparam logic [DIV_W-1:0]  EPOCH_SHIFT    = 22'd79;
  localparam logic [YEAR_W-1:0] JAL_BASE_YEAR  = 14'd979;
  localparam logic [MONTH_W-1:0] LAST_MONTH    = 4'd11;

  // Divisors
  localparam logic [REM_W-1:0] DIV_CENTURY = 14'd100;
  localparam logic [REM_W-1:0] DIV_CYCLE   = 14'd12053;
  localparam logic [REM_W-1:0] DIV_QUAD    = 14'd1461;
  localparam logic [REM_W-1:0] DIV_YEAR    = 14'd365;

  // Reciprocals: quotient is (x * RECIP) >> SHIFT, exact over each dividend range
  localparam logic [DIV_W-1:0] RECIP_CENTURY = 22'd5243;
  localparam logic [DIV_W-1:0] RECIP_CYCLE   = 22'd2850721;
  localparam logic [DIV_W-1:0] RECIP_QUAD    = 22'd11484;
  localparam logic [DIV_W-1:0] RECIP_YEAR    = 22'd1437;
  localparam int SHIFT_CENTURY = 19;
  localparam int SHIFT_CYCLE   = 35;
  localparam int SHIFT_QUAD    = 24;
  localparam int SHIFT_YEAR    = 19;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV100,
    ST_MUL,
    ST_SUM,
    ST_DIVCYC,
    ST_DIVQUAD,
    ST_YEARCHK,
    ST_DIVYEAR,
    ST_MONTH,
    ST_DONE
  } gtj_state_t;

  // Divider operations
  typedef enum logic [2:0] {
    OP_C100,
    OP_CYC,
    OP_QUAD,
    OP_YEAR
  } div_op_t;

  // Sequencer to datapath controls
  typedef struct packed {
    logic    in_ready;
    logic    load;
    div_op_t load_op;
    logic    cap;
    div_op_t cap_op;
    logic    mul_en;
    logic    month_step;
    logic    out_en;
  } gtj_ctrl_t;

  // Datapath to sequencer status
  typedef struct packed {
    logic div_done;
    logic year_long;
    logic month_more;
    logic out_free;
  } gtj_stat_t;

  // Days before the given zero-based Gregorian month, non-leap
  function automatic logic [8:0] greg_cum(input logic [MONTH_W-1:0] gm);
    logic [8:0] res;
    unique case (gm)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd31;
      4'd2:    res = 9'd59;
      4'd3:    res = 9'd90;
      4'd4:    res = 9'd120;
      4'd5:    res = 9'd151;
      4'd6:    res = 9'd181;
      4'd7:    res = 9'd212;
      4'd8:    res = 9'd243;
      4'd9:    res = 9'd273;
      4'd10:   res = 9'd304;
      4'd11:   res = 9'd334;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

  // Length of the given zero-based Jalali month
  function automatic logic [DAY_W-1:0] jal_len(input logic [MONTH_W-1:0] jm);
    logic [DAY_W-1:0] res;
    unique case (jm)
      4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5: res = 5'd31;
      4'd6, 4'd7, 4'd8, 4'd9, 4'd10:      res = 5'd30;
      default:                            res = 5'd29;
    endcase
    return res;
  endfunction

endpackage

### rtl/gregorian_to_jalali_date_unit.sv
// Top level of the Gregorian to Jalali date unit: datapath, divider and sequencer.
//
//   Channel  Dir  Payload (low bit first)
//   s_*      in   greg_year[13:0], greg_month[17:14], greg_day[22:18], zero[23]
//   m_*      out  jal_year[13:0], jal_month[17:14], jal_day[22:18], zero[23]
//
// One date runs from the accepting edge to the edge that loads the result register
// through three or four constant divisions on the shared reciprocal multiplier and
// a month walk of up to eleven steps. s_tready is high only while the unit is idle,
// so no new word is taken while a date is still being converted or waits for output.
// The result sits in an output register; a stalled m_tready holds the next result
// in the last state until that register frees up. Reset is synchronous and clears
// the sequencer, the divider phase count and m_tvalid.
module gregorian_to_jalali_date_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [gtj_pkg::TDATA_W-1:0]  s_tdata,   // greg_year, greg_month, greg_day
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [gtj_pkg::TDATA_W-1:0]  m_tdata    // jal_year, jal_month, jal_day
);
  import gtj_pkg::*;

  gtj_ctrl_t ctrl;
  gtj_stat_t stat;

  // Input field decode and saturation
  logic [YEAR_W-1:0]  in_year;
  logic [MONTH_W-1:0] in_month;
  logic [DAY_W-1:0]   in_day;
  logic [YEAR_W-1:0]  year_sat;
  logic [MONTH_W-1:0] month_sat;
  logic [DAY_W-1:0]   day_sat;
  logic [YEAR_W-1:0]  gy_in;

  // Datapath registers
  logic [YEAR_W-1:0]  gy;
  logic [MONTH_W-1:0] gm;
  logic [DAY_W-1:0]   gd;
  logic [6:0]         c100;
  logic               r100_nz;
  logic [4:0]         c400;
  logic               r400_z;
  logic [DIV_W-1:0]   prod;
  logic [YEAR_W-1:0]  corr;
  logic [YEAR_W-1:0]  jy;
  logic [MONTH_W-1:0] jm;
  logic [DAYS_W-1:0]  days;

  // Combinational datapath
  logic [DIV_W:0]     prod_full;
  logic [YEAR_W-1:0]  quarter;
  logic               leap;
  logic [YEAR_W-1:0]  corr_next;
  logic [DIV_W-1:0]   days_sum;
  logic [DAYS_W-1:0]  days_m1;
  logic [DAYS_W-1:0]  days_step;

  // Divider hookup
  logic [DIV_W-1:0]   div_dividend;
  logic [QUO_W-1:0]   div_quot;
  logic [REM_W-1:0]   div_rem;
  logic               div_done;

  // Saturate the incoming word
  always_comb begin
    in_year  = s_tdata[YEAR_W-1:0];
    in_month = s_tdata[YEAR_W+MONTH_W-1:YEAR_W];
    in_day   = s_tdata[YEAR_W+MONTH_W+DAY_W-1:YEAR_W+MONTH_W];
    if (in_year < GY_MIN) begin
      year_sat = GY_MIN;
    end else if (in_year > GY_MAX) begin
      year_sat = GY_MAX;
    end else begin
      year_sat = in_year;
    end
    if (in_month == '0) begin
      month_sat = 4'd1;
    end else if (in_month > MONTH_MAX) begin
      month_sat = MONTH_MAX;
    end else begin
      month_sat = in_month;
    end
    day_sat = (in_day == '0) ? 5'd1 : in_day;
    gy_in   = year_sat - BASE_YEAR;
  end

  // Day count pieces: whole years, leap corrections, months, day
  always_comb begin
    prod_full = gy * DAYS_YEAR;
    quarter   = (gy + 14'd3) >> 2;
    leap      = (gm > 4'd1) && (gy[1:0] == 2'b00) && (r100_nz || r400_z);
    corr_next = quarter - YEAR_W'(c100) + YEAR_W'(c400) + YEAR_W'(greg_cum(gm))
                + YEAR_W'(leap) + YEAR_W'(gd);
    days_sum  = prod + DIV_W'(corr) - EPOCH_SHIFT;
    days_m1   = days - 11'd1;
    days_step = days - DAYS_W'(jal_len(jm));
  end

  // Select divider operand
  always_comb begin
    unique case (ctrl.load_op)
      OP_C100: div_dividend = DIV_W'(gy_in);
      OP_CYC:  div_dividend = days_sum;
      OP_QUAD: div_dividend = DIV_W'(div_rem);
      OP_YEAR: div_dividend = DIV_W'(days_m1);
      default: div_dividend = '0;
    endcase
  end

  gtj_div u_div (
    .clk      (clk),
    .rst      (rst),
    .load     (ctrl.load),
    .op       (ctrl.load_op),
    .dividend (div_dividend),
    .quot     (div_quot),
    .rem      (div_rem),
    .done     (div_done)
  );

  // Status back to the sequencer
  always_comb begin
    stat.div_done   = div_done;
    stat.year_long  = (days >= DAYS_LEAP_YEAR);
    stat.month_more = (jm < LAST_MONTH) && (days >= DAYS_W'(jal_len(jm)));
    stat.out_free   = !m_tvalid || m_tready;
  end

  gtj_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  assign s_tready = ctrl.in_ready;

  // Capture the word and the division results
  always_ff @(posedge clk) begin
    if (ctrl.in_ready && s_tvalid) begin
      gy <= gy_in;
      gm <= month_sat - 4'd1;
      gd <= day_sat - 5'd1;
      jm <= '0;
    end
    if (ctrl.mul_en) begin
      prod <= prod_full[DIV_W-1:0];
      corr <= corr_next;
    end
    if (ctrl.cap) begin
      unique case (ctrl.cap_op)
        OP_C100: begin
          // quadricentennial terms follow from the century quotient
          c100    <= div_quot[6:0] + 7'(div_rem != '0);
          r100_nz <= (div_rem != '0);
          c400    <= div_quot[6:2] + 5'((div_rem != '0) || (div_quot[1:0] != 2'b00));
          r400_z  <= (div_rem == '0) && (div_quot[1:0] == 2'b00);
        end
        OP_CYC: begin
          jy <= JAL_BASE_YEAR + (YEAR_W'(div_quot[7:0]) << 5) + YEAR_W'(div_quot[7:0]);
        end
        OP_QUAD: begin
          jy   <= jy + YEAR_W'({div_quot[3:0], 2'b00});
          days <= div_rem[DAYS_W-1:0];
        end
        OP_YEAR: begin
          jy   <= jy + YEAR_W'(div_quot[1:0]);
          days <= div_rem[DAYS_W-1:0];
        end
        default: begin
          jy <= jy;
        end
      endcase
    end
    if (ctrl.month_step) begin
      days <= days_step;
      jm   <= jm + 4'd1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.out_en) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_en) begin
      m_tdata <= {1'b0, days[DAY_W-1:0] + 5'd1, jm + 4'd1, jy};
    end
  end

  // A word taken in starts a run that drops ready on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("ready stayed high after a word was taken");

  // The divider is only reloaded once its previous division has finished
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    ctrl.load |-> div_done)
    else $error("divider reloaded while busy");

  // Results are only captured from a finished division
  a_cap_done: assert property (@(posedge clk) disable iff (rst)
    ctrl.cap |-> div_done)
    else $error("divider result captured before finishing");

  // The month walk leaves a day within the month
  a_day_range: assert property (@(posedge clk) disable iff (rst)
    ctrl.out_en |-> (days <= 11'd30) && (jm <= LAST_MONTH))
    else $error("day or month out of range at output");

endmodule

### rtl/gtj_div.sv
// Shared constant divider: reciprocal multiply, then remainder, on one multiplier.
module gtj_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  gtj_pkg::div_op_t           op,
  input  logic [gtj_pkg::DIV_W-1:0]  dividend,
  output logic [gtj_pkg::QUO_W-1:0]  quot,
  output logic [gtj_pkg::REM_W-1:0]  rem,
  output logic                       done
);
  import gtj_pkg::*;

  localparam logic [1:0] PH_EST = 2'd2;
  localparam logic [1:0] PH_REM = 2'd1;

  div_op_t           op_r;
  logic [DIV_W-1:0]  x;
  logic [QUO_W-1:0]  q;
  logic [REM_W-1:0]  r;
  logic [1:0]        cnt;
  logic [DIV_W-1:0]  recip;
  logic [REM_W-1:0]  d;
  logic [DIV_W-1:0]  mul_a;
  logic [DIV_W-1:0]  mul_b;
  logic [PROD_W-1:0] prod;
  logic [QUO_W-1:0]  q_est;
  logic [DIV_W-1:0]  diff;

  // Constants of the selected division
  always_comb begin
    unique case (op_r)
      OP_C100: begin
        recip = RECIP_CENTURY;
        d     = DIV_CENTURY;
      end
      OP_CYC: begin
        recip = RECIP_CYCLE;
        d     = DIV_CYCLE;
      end
      OP_QUAD: begin
        recip = RECIP_QUAD;
        d     = DIV_QUAD;
      end
      OP_YEAR: begin
        recip = RECIP_YEAR;
        d     = DIV_YEAR;
      end
      default: begin
        recip = RECIP_CENTURY;
        d     = DIV_CENTURY;
      end
    endcase
  end

  // Shared multiplier: dividend times reciprocal, then quotient times divisor
  always_comb begin
    mul_a = (cnt == PH_EST) ? x : DIV_W'(q);
    mul_b = (cnt == PH_EST) ? recip : DIV_W'(d);
    prod  = mul_a * mul_b;
    unique case (op_r)
      OP_C100: q_est = prod[SHIFT_CENTURY +: QUO_W];
      OP_CYC:  q_est = prod[SHIFT_CYCLE +: QUO_W];
      OP_QUAD: q_est = prod[SHIFT_QUAD +: QUO_W];
      OP_YEAR: q_est = prod[SHIFT_YEAR +: QUO_W];
      default: q_est = prod[SHIFT_CENTURY +: QUO_W];
    endcase
    diff = x - prod[DIV_W-1:0];
  end

  // Phase counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= PH_EST;
    end else if (cnt != '0) begin
      cnt <= cnt - 2'd1;
    end
  end

  // Operands, quotient and remainder
  always_ff @(posedge clk) begin
    if (load) begin
      x    <= dividend;
      op_r <= op;
    end else if (cnt == PH_EST) begin
      q <= q_est;
    end else if (cnt == PH_REM) begin
      r <= diff[REM_W-1:0];
    end
  end

  assign quot = q;
  assign rem  = r;
  assign done = (cnt == '0);

endmodule

### rtl/gtj_seq.sv
// Sequencer that steps the conversion through the shared divider.
module gtj_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  gtj_pkg::gtj_stat_t stat,
  output gtj_pkg::gtj_ctrl_t ctrl
);
  import gtj_pkg::*;

  gtj_state_t state;
  gtj_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (in_valid) state_next = ST_DIV100;
      ST_DIV100:  if (stat.div_done) state_next = ST_MUL;
      ST_MUL:     state_next = ST_SUM;
      ST_SUM:     state_next = ST_DIVCYC;
      ST_DIVCYC:  if (stat.div_done) state_next = ST_DIVQUAD;
      ST_DIVQUAD: if (stat.div_done) state_next = ST_YEARCHK;
      ST_YEARCHK: state_next = stat.year_long ? ST_DIVYEAR : ST_MONTH;
      ST_DIVYEAR: if (stat.div_done) state_next = ST_MONTH;
      ST_MONTH:   if (!stat.month_more) state_next = ST_DONE;
      ST_DONE:    if (stat.out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Controls
  always_comb begin
    ctrl = '{in_ready: 1'b0, load: 1'b0, load_op: OP_C100, cap: 1'b0, cap_op: OP_C100,
             mul_en: 1'b0, month_step: 1'b0, out_en: 1'b0};
    unique case (state)
      ST_IDLE: begin
        ctrl.in_ready = 1'b1;
        ctrl.load     = in_valid;
        ctrl.load_op  = OP_C100;
      end
      ST_DIV100: begin
        ctrl.cap    = stat.div_done;
        ctrl.cap_op = OP_C100;
      end
      ST_MUL: begin
        ctrl.mul_en = 1'b1;
      end
      ST_SUM: begin
        ctrl.load    = 1'b1;
        ctrl.load_op = OP_CYC;
      end
      ST_DIVCYC: begin
        ctrl.cap     = stat.div_done;
        ctrl.cap_op  = OP_CYC;
        ctrl.load    = stat.div_done;
        ctrl.load_op = OP_QUAD;
      end
      ST_DIVQUAD: begin
        ctrl.cap    = stat.div_done;
        ctrl.cap_op = OP_QUAD;
      end
      ST_YEARCHK: begin
        ctrl.load    = stat.year_long;
        ctrl.load_op = OP_YEAR;
      end
      ST_DIVYEAR: begin
        ctrl.cap    = stat.div_done;
        ctrl.cap_op = OP_YEAR;
      end
      ST_MONTH: begin
        ctrl.month_step = stat.month_more;
      end
      ST_DONE: begin
        ctrl.out_en = stat.out_free;
      end
      default: begin
        ctrl.in_ready = 1'b0;
      end
    endcase
  end

endmodule
